FILE: hw/rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Holds the command codes, character codes, stream field layout and the
// decoded operation passed from the front end to the execution back end.
package tcw_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Field widths
    localparam int CMD_W        = 2;
    localparam int CHAR_W       = 8;
    localparam int ATTR_W       = 8;
    localparam int CELL_INDEX_W = 11;
    localparam int CURSOR_COL_W = 7;
    localparam int CURSOR_ROW_W = 5;
    localparam int CELL_W       = CHAR_W + ATTR_W;

    // Stream layout
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;
    localparam int CHAR_LSB  = 0;
    localparam int INDEX_LSB = CHAR_W;

    // Command codes carried on s_tuser
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Character and attribute codes
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'd32;
    localparam logic [ATTR_W-1:0] RESET_ATTR     = 8'h07;

    // Depth of the request queue between front and back end
    localparam int QUEUE_DEPTH = 2;

    // Decoded operation
    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } op_kind_t;

    typedef struct packed {
        op_kind_t                kind;
        logic [CHAR_W-1:0]       char_code;
        logic [CELL_INDEX_W-1:0] cell_index;
    } op_t;

    // Result fields, last field in the lowest bits
    typedef struct packed {
        logic                    screen_cleared;
        logic                    cell_written;
        logic [ATTR_W-1:0]       read_attr;
        logic [CHAR_W-1:0]       read_char;
        logic [CURSOR_ROW_W-1:0] cursor_row;
        logic [CURSOR_COL_W-1:0] cursor_col;
    } result_t;

endpackage

FILE: hw/rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/tcw_front.sv
// Front end of the text console writer: accepts stream requests and
// classifies them into decoded operations. Depends on tcw_pkg.
module tcw_front
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 init_done,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [CMD_W-1:0]     s_tuser,
    output logic                 op_valid,
    input  logic                 op_ready,
    output op_t                  op
);

    localparam int CellCount = COLUMNS * ROWS;
    localparam int AddrW     = $clog2(CellCount);
    localparam int CmpW      = ((AddrW > CELL_INDEX_W) ? AddrW : CELL_INDEX_W) + 1;

    logic                    valid_reg;
    op_t                     op_reg;
    op_t                     op_next;
    logic [CHAR_W-1:0]       char_code;
    logic [CELL_INDEX_W-1:0] cell_index;
    logic [CmpW-1:0]         index_ext;
    logic                    in_range;
    logic                    accept;

    assign char_code  = s_tdata[CHAR_LSB +: CHAR_W];
    assign cell_index = s_tdata[INDEX_LSB +: CELL_INDEX_W];
    assign index_ext  = CmpW'(cell_index);
    assign in_range   = index_ext < CmpW'(CellCount);

    // Take a request once the reset sweep is done, while the stage is empty or draining into the queue
    assign s_tready = init_done && (!valid_reg || op_ready);
    assign accept   = s_tvalid && s_tready;

    // Classify the request
    always_comb
    begin
        op_next.char_code  = char_code;
        op_next.cell_index = cell_index;
        unique case (s_tuser)
            CMD_PUT:
            begin
                if (char_code == CHAR_NEWLINE)
                begin
                    op_next.kind = OP_NEWLINE;
                end
                else if (char_code == CHAR_BACKSPACE)
                begin
                    op_next.kind = OP_BACKSPACE;
                end
                else
                begin
                    op_next.kind = OP_PUT;
                end
            end
            CMD_CLEAR:
            begin
                op_next.kind = OP_CLEAR;
            end
            CMD_READ:
            begin
                // Reads beyond the store report zeros, as an empty command
                op_next.kind = in_range ? OP_READ : OP_NOP;
            end
            default:
            begin
                op_next.kind = OP_NOP;
            end
        endcase
    end

    // Hold the decoded operation until the queue takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (op_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op_next;
        end
    end

    assign op_valid = valid_reg;
    assign op       = op_reg;

endmodule

FILE: hw/rtl/tcw_queue.sv
// Short request queue between the front end and the back end.
// Depends on tcw_pkg for the operation type and depth.
module tcw_queue
    import tcw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  op_t  push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output op_t  pop_data
);

    localparam int PtrW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CountW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0]   LastPtr = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [CountW-1:0] Full    = CountW'(QUEUE_DEPTH);

    op_t               entry_reg [QUEUE_DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [CountW-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != Full;
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/tcw_back.sv
// Back end of the text console writer: cursor, attribute register, cell
// store sweep and result register. Depends on tcw_pkg and tcw_ram.
module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [ATTR_W-1:0] cfg_wr_data,
    input  logic              op_valid,
    output logic              op_ready,
    input  op_t               op,
    output logic              init_done,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res
);

    localparam int CellCount = COLUMNS * ROWS;
    localparam int AddrW     = $clog2(CellCount);
    localparam int ColW      = $clog2(COLUMNS);
    localparam int RowW      = $clog2(ROWS);
    localparam logic [ColW:0]      ColLimit  = (ColW + 1)'(COLUMNS);
    localparam logic [RowW:0]      RowLimit  = (RowW + 1)'(ROWS);
    localparam logic [AddrW-1:0]   LastCell  = AddrW'(CellCount - 1);

    typedef enum logic [1:0] {
        ST_WIPE,
        ST_IDLE,
        ST_READ
    } state_t;

    state_t            state_reg;
    logic              init_done_reg;
    logic [ColW-1:0]   col_reg;
    logic [RowW-1:0]   row_reg;
    logic [ATTR_W-1:0] attr_reg;
    logic [AddrW-1:0]  sweep_addr_reg;
    logic [ATTR_W-1:0] sweep_attr_reg;
    logic              sweep_report_reg;
    logic              sweep_written_reg;
    logic              res_valid_reg;
    result_t           res_reg;

    logic              out_free;
    logic              pop;
    logic              res_load;
    logic [ColW:0]     col_inc;
    logic [RowW:0]     row_inc;
    logic [ColW-1:0]   col_dec;
    logic              col_wrap;
    logic              row_wrap;
    logic              bs_ok;
    logic [ColW-1:0]   col_next;
    logic [RowW-1:0]   row_next;
    logic              wipe_next;
    logic              written_next;
    logic [AddrW-1:0]  row_base;
    logic [ColW-1:0]   write_col;
    logic              ram_wr_en;
    logic [AddrW-1:0]  ram_wr_addr;
    logic [CELL_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [AddrW-1:0]  ram_rd_addr;
    logic [CELL_W-1:0] ram_rd_data;

    // Take the next request only when the result slot frees up
    assign out_free = !res_valid_reg || res_ready;
    assign pop      = (state_reg == ST_IDLE) && op_valid && out_free;
    assign op_ready = pop;

    // Cursor arithmetic
    assign col_inc  = {1'b0, col_reg} + 1'b1;
    assign row_inc  = {1'b0, row_reg} + 1'b1;
    assign col_dec  = col_reg - 1'b1;
    assign col_wrap = col_inc == ColLimit;
    assign row_wrap = row_inc == RowLimit;
    assign bs_ok    = col_reg != '0;

    // Work out the cursor move and side effects of the request
    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        wipe_next    = 1'b0;
        written_next = 1'b0;
        unique case (op.kind)
            OP_PUT:
            begin
                written_next = 1'b1;
                if (col_wrap)
                begin
                    col_next = '0;
                    if (row_wrap)
                    begin
                        wipe_next = 1'b1;
                    end
                    else
                    begin
                        row_next = row_inc[RowW-1:0];
                    end
                end
                else
                begin
                    col_next = col_inc[ColW-1:0];
                end
            end
            OP_NEWLINE:
            begin
                col_next = '0;
                if (row_wrap)
                begin
                    wipe_next = 1'b1;
                end
                else
                begin
                    row_next = row_inc[RowW-1:0];
                end
            end
            OP_BACKSPACE:
            begin
                if (bs_ok)
                begin
                    col_next     = col_dec;
                    written_next = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                wipe_next = 1'b1;
            end
            OP_READ, OP_NOP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Load a result at the end of a reported sweep, on a plain request or on a read return
    assign res_load = ((state_reg == ST_WIPE) && (sweep_addr_reg == LastCell) && sweep_report_reg)
                   || (pop && !wipe_next && (op.kind != OP_READ))
                   || (state_reg == ST_READ);

    // Cell store ports: the sweep owns the write port while it runs
    assign row_base  = AddrW'(row_reg * COLUMNS);
    assign write_col = (op.kind == OP_BACKSPACE) ? col_dec : col_reg;

    always_comb
    begin
        if (state_reg == ST_WIPE)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_addr_reg;
            ram_wr_data = {sweep_attr_reg, CHAR_BLANK};
        end
        else
        begin
            ram_wr_en   = pop && written_next;
            ram_wr_addr = row_base + AddrW'(write_col);
            ram_wr_data = {attr_reg,
                           (op.kind == OP_PUT) ? op.char_code : CHAR_BLANK};
        end
    end

    assign ram_rd_en   = pop && (op.kind == OP_READ);
    assign ram_rd_addr = AddrW'(op.cell_index);

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CellCount)
    ) u_cells (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Sequencer: sweep, execute, read return and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_WIPE;
            init_done_reg     <= 1'b0;
            col_reg           <= '0;
            row_reg           <= '0;
            attr_reg          <= RESET_ATTR;
            sweep_addr_reg    <= '0;
            sweep_attr_reg    <= RESET_ATTR;
            sweep_report_reg  <= 1'b0;
            sweep_written_reg <= 1'b0;
            res_valid_reg     <= 1'b0;
            res_reg           <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                attr_reg <= cfg_wr_data;
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_WIPE:
                begin
                    sweep_addr_reg <= sweep_addr_reg + 1'b1;
                    if (sweep_addr_reg == LastCell)
                    begin
                        state_reg     <= ST_IDLE;
                        init_done_reg <= 1'b1;
                        if (sweep_report_reg)
                        begin
                            res_reg.cursor_col     <= '0;
                            res_reg.cursor_row     <= '0;
                            res_reg.read_char      <= '0;
                            res_reg.read_attr      <= '0;
                            res_reg.cell_written   <= sweep_written_reg;
                            res_reg.screen_cleared <= 1'b1;
                        end
                    end
                end
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        if (wipe_next)
                        begin
                            // Home the cursor and sweep blanks over the store
                            state_reg         <= ST_WIPE;
                            sweep_addr_reg    <= '0;
                            sweep_attr_reg    <= attr_reg;
                            sweep_report_reg  <= 1'b1;
                            sweep_written_reg <= written_next;
                            col_reg           <= '0;
                            row_reg           <= '0;
                        end
                        else if (op.kind == OP_READ)
                        begin
                            state_reg <= ST_READ;
                        end
                        else
                        begin
                            col_reg                <= col_next;
                            row_reg                <= row_next;
                            res_reg.cursor_col     <= CURSOR_COL_W'(col_next);
                            res_reg.cursor_row     <= CURSOR_ROW_W'(row_next);
                            res_reg.read_char      <= '0;
                            res_reg.read_attr      <= '0;
                            res_reg.cell_written   <= written_next;
                            res_reg.screen_cleared <= 1'b0;
                        end
                    end
                end
                ST_READ:
                begin
                    // Return the cell once the store has answered
                    state_reg              <= ST_IDLE;
                    res_reg.cursor_col     <= CURSOR_COL_W'(col_reg);
                    res_reg.cursor_row     <= CURSOR_ROW_W'(row_reg);
                    res_reg.read_char      <= ram_rd_data[CHAR_W-1:0];
                    res_reg.read_attr      <= ram_rd_data[CELL_W-1:CHAR_W];
                    res_reg.cell_written   <= 1'b0;
                    res_reg.screen_cleared <= 1'b0;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign init_done = init_done_reg;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: hw/rtl/text_console_writer.sv
// Text console writer: character-cell console with cursor and cell store. Depends on tcw_pkg.
// Results pass the front register, queue entry and result register; in-store reads also pass
// the RAM read register; a clear or a put/newline past the last row waits for the sweep.
// Throughput: one put, newline, backspace, unused or out-of-range read request a cycle while
// results are taken; in-store reads and clears stall the back end (one cell written a cycle).
// Reset: cursor home, attribute 7, store blanked by a sweep over every cell with s_tready low.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // Attribute register write
    input  logic                 cfg_wr_en,
    input  logic [ATTR_W-1:0]    cfg_wr_data,
    // Request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [7:0] char_code, [18:8] cell_index, rest zero
    input  logic [CMD_W-1:0]     s_tuser,  // [1:0] cmd
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // [6:0] cursor_col, [11:7] cursor_row,
                                           // [19:12] read_char, [27:20] read_attr,
                                           // [28] cell_written, [29] screen_cleared
);

    logic    init_done;
    logic    front_valid;
    logic    front_ready;
    op_t     front_op;
    logic    queue_valid;
    logic    queue_ready;
    op_t     queue_op;
    result_t res;

    // Accept and classify requests
    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .init_done (init_done),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .op_valid  (front_valid),
        .op_ready  (front_ready),
        .op        (front_op)
    );

    // Decouple front and back end
    tcw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_op),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_op)
    );

    // Execute against the cursor and the cell store
    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .op_valid    (queue_valid),
        .op_ready    (queue_ready),
        .op          (queue_op),
        .init_done   (init_done),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res)
    );

    assign m_tdata = M_TDATA_W'(res);

    // A cleared screen always reports the cursor at home
    a_clear_homes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.screen_cleared |-> res.cursor_col == '0 && res.cursor_row == '0)
        else $error("clear result with cursor away from home");

    // Only reads return cell contents
    a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (res.cell_written || res.screen_cleared)
            |-> res.read_char == '0 && res.read_attr == '0)
        else $error("cell contents on a non-read result");

    // No request enters and no result leaves while the reset sweep runs
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        !init_done |-> !s_tready && !m_tvalid)
        else $error("request or result during reset sweep");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the text console writer: directed table, wrap runs, then random phases.
// Predicts cursor, cell reads, write and clear flags from a shadow of the cell store.
// Depends on tcw_pkg and text_console_writer.
module tb_top;
    import tcw_pkg::*;

    localparam int CELL_COUNT  = DEF_COLUMNS * DEF_ROWS;
    localparam int MAX_GAP     = 50;
    localparam int IDLE_PAUSE  = 8;
    localparam int DRAIN_CYCLES = 20;
    localparam int QUIET_LIMIT = 40000;
    localparam int PHASE_ITEMS = 240;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum logic {ROW_REQUEST, ROW_ATTR} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic [CMD_W-1:0]        cmd;
        logic [CHAR_W-1:0]       ch;
        logic [CELL_INDEX_W-1:0] idx;
        bit                      fixed;
        result_t                 want;
        logic [ATTR_W-1:0]       attr;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [ATTR_W-1:0]    cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;  // [7:0] char_code, [18:8] cell_index, rest zero
    logic [CMD_W-1:0]     s_tuser = '0;  // [1:0] cmd
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;       // [6:0] cursor_col, [11:7] cursor_row,
                                         // [19:12] read_char, [27:20] read_attr,
                                         // [28] cell_written, [29] screen_cleared

    // Shadow console state
    logic [CELL_W-1:0] shadow_cells [CELL_COUNT];
    int                shadow_col;
    int                shadow_row;
    logic [ATTR_W-1:0] shadow_attr;

    result_t     pending_results [$];
    stim_row_t   stim_table [$];
    bit          req_fixed = 1'b0;
    result_t     req_want = '0;
    result_t     predicted;
    result_t     observed;
    result_t     oldest;
    int          failures = 0;
    int          quiet_cycles = 0;
    int          ready_hold = 0;
    int          ready_gap;
    bit          no_gaps = 1'b0;

    text_console_writer #(
        .COLUMNS (DEF_COLUMNS),
        .ROWS    (DEF_ROWS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #6 clk = ~clk;

    // Blank every shadow cell with the current attribute and send the cursor home
    function automatic void wipe_shadow();
        for (int i = 0; i < CELL_COUNT; i++)
        begin
            shadow_cells[i] = {shadow_attr, CHAR_BLANK};
        end
        shadow_col = 0;
        shadow_row = 0;
    endfunction

    // Apply one request to the shadow console and return the result it causes
    function automatic result_t console_step(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                             logic [CELL_INDEX_W-1:0] idx);
        result_t res;
        res = '0;
        case (cmd)
            CMD_PUT:
            begin
                if (ch == CHAR_NEWLINE)
                begin
                    shadow_col = 0;
                    shadow_row++;
                end
                else if (ch == CHAR_BACKSPACE)
                begin
                    if (shadow_col > 0)
                    begin
                        shadow_col--;
                        shadow_cells[shadow_row * DEF_COLUMNS + shadow_col] =
                            {shadow_attr, CHAR_BLANK};
                        res.cell_written = 1'b1;
                    end
                end
                else
                begin
                    shadow_cells[shadow_row * DEF_COLUMNS + shadow_col] = {shadow_attr, ch};
                    res.cell_written = 1'b1;
                    shadow_col++;
                    if (shadow_col >= DEF_COLUMNS)
                    begin
                        shadow_col = 0;
                        shadow_row++;
                    end
                end
                // Running past the last row wipes the screen, no scrolling
                if (shadow_row >= DEF_ROWS)
                begin
                    wipe_shadow();
                    res.screen_cleared = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                wipe_shadow();
                res.screen_cleared = 1'b1;
            end
            CMD_READ:
            begin
                if (idx < CELL_COUNT)
                begin
                    res.read_char = shadow_cells[idx][CHAR_W-1:0];
                    res.read_attr = shadow_cells[idx][CELL_W-1:CHAR_W];
                end
            end
            default: ;
        endcase
        res.cursor_col = shadow_col[CURSOR_COL_W-1:0];
        res.cursor_row = shadow_row[CURSOR_ROW_W-1:0];
        return res;
    endfunction

    function automatic result_t mk_res(int col, int row, logic [CHAR_W-1:0] rch,
                                       logic [ATTR_W-1:0] rattr, bit wr, bit clr);
        result_t r;
        r.cursor_col     = col[CURSOR_COL_W-1:0];
        r.cursor_row     = row[CURSOR_ROW_W-1:0];
        r.read_char      = rch;
        r.read_attr      = rattr;
        r.cell_written   = wr;
        r.screen_cleared = clr;
        return r;
    endfunction

    function automatic void add_request(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                        logic [CELL_INDEX_W-1:0] idx, bit fixed,
                                        result_t want);
        stim_row_t row;
        row.kind  = ROW_REQUEST;
        row.cmd   = cmd;
        row.ch    = ch;
        row.idx   = idx;
        row.fixed = fixed;
        row.want  = want;
        row.attr  = '0;
        stim_table.push_back(row);
    endfunction

    function automatic void add_attr(logic [ATTR_W-1:0] value);
        stim_row_t row;
        row.kind  = ROW_ATTR;
        row.cmd   = CMD_PUT;
        row.ch    = '0;
        row.idx   = '0;
        row.fixed = 1'b0;
        row.want  = '0;
        row.attr  = value;
        stim_table.push_back(row);
    endfunction

    // Mostly back to back, some short gaps, a few long ones
    function automatic int gap_len();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, MAX_GAP);
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            failures++;
        end
    endfunction

    // Offer one request from a falling edge; return at the falling edge after it is taken
    task automatic send_req(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                            logic [CELL_INDEX_W-1:0] idx, bit fixed, result_t want);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {{(S_TDATA_W - CELL_INDEX_W - CHAR_W){1'b0}}, idx, ch};
        s_tuser   <= cmd;
        req_fixed <= fixed;
        req_want  <= want;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Write the attribute only once the block has drained
    task automatic set_attribute(logic [ATTR_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (IDLE_PAUSE) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_attr = value;
    endtask

    // Draw one random request; counted is low for commands the block ignores
    task automatic random_request(output bit counted);
        int                      r;
        int                      sub;
        int                      near;
        logic [CMD_W-1:0]        cmd;
        logic [CHAR_W-1:0]       ch;
        logic [CELL_INDEX_W-1:0] idx;
        r       = $urandom_range(0, 99);
        sub     = $urandom_range(0, 99);
        ch      = 8'($urandom_range(0, 255));
        idx     = 11'($urandom_range(0, 2047));
        counted = 1'b1;
        if (r < 60)
        begin
            cmd = CMD_PUT;
            if (sub < 8)
                ch = CHAR_NEWLINE;
            else if (sub < 20)
                ch = CHAR_BACKSPACE;
        end
        else if (r < 90)
        begin
            cmd = CMD_READ;
            // Favour cells around the cursor, where recent writes landed
            if (sub < 60)
            begin
                near = shadow_row * DEF_COLUMNS + $urandom_range(0, 2 * DEF_COLUMNS - 1);
                idx  = (near > 2047) ? 11'd2047 : near[CELL_INDEX_W-1:0];
            end
            else if (sub < 85)
                idx = 11'($urandom_range(0, CELL_COUNT - 1));
            else if (sub < 95)
                idx = 11'($urandom_range(CELL_COUNT, 2047));
        end
        else if (r < 92)
            cmd = CMD_CLEAR;
        else
        begin
            cmd     = CMD_UNUSED;
            counted = 1'b0;
        end
        send_req(cmd, ch, idx, 1'b0, '0);
    endtask

    // Predict on each accepted request and watch for a stalled run
    always @(posedge clk)
    begin
        quiet_cycles++;
        if (rst_n && s_tvalid && s_tready)
        begin
            predicted = console_step(s_tuser, s_tdata[CHAR_LSB +: CHAR_W],
                                     s_tdata[INDEX_LSB +: CELL_INDEX_W]);
            pending_results.push_back(req_fixed ? req_want : predicted);
            quiet_cycles = 0;
        end
        if (quiet_cycles > QUIET_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("text_console_writer regression: fail");
            $finish;
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            observed = m_tdata[$bits(result_t)-1:0];
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected, expected nothing, got %h",
                         $time, observed);
                failures++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                check_field("cursor_col", oldest.cursor_col, observed.cursor_col);
                check_field("cursor_row", oldest.cursor_row, observed.cursor_row);
                check_field("read_char", oldest.read_char, observed.read_char);
                check_field("read_attr", oldest.read_attr, observed.read_attr);
                check_field("cell_written", oldest.cell_written, observed.cell_written);
                check_field("screen_cleared", oldest.screen_cleared, observed.screen_cleared);
            end
        end
    end

    // Stall the result side at random
    always @(negedge clk)
    begin
        if (ready_hold > 0)
            ready_hold--;
        else
        begin
            ready_gap = gap_len();
            if (ready_gap > 0)
            begin
                m_tready   <= 1'b0;
                ready_hold = ready_gap - 1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        bit               counted;
        int               done;
        logic [ATTR_W-1:0] phase_attr;

        shadow_attr = RESET_ATTR;
        wipe_shadow();

        // Directed requests; fixed results where they are obvious
        add_request(CMD_READ, 8'h00, 11'd0, 1'b1, mk_res(0, 0, CHAR_BLANK, RESET_ATTR, 0, 0));
        add_request(CMD_READ, 8'h00, 11'd1999, 1'b1,
                    mk_res(0, 0, CHAR_BLANK, RESET_ATTR, 0, 0));
        add_request(CMD_READ, 8'hFF, 11'd2047, 1'b1, mk_res(0, 0, 8'h00, 8'h00, 0, 0));
        add_request(CMD_UNUSED, 8'hFF, 11'h7FF, 1'b1, mk_res(0, 0, 8'h00, 8'h00, 0, 0));
        add_request(CMD_PUT, CHAR_BACKSPACE, 11'd0, 1'b1, mk_res(0, 0, 8'h00, 8'h00, 0, 0));
        add_request(CMD_PUT, 8'h41, 11'h7FF, 1'b1, mk_res(1, 0, 8'h00, 8'h00, 1, 0));
        add_request(CMD_PUT, 8'hFF, 11'd0, 1'b1, mk_res(2, 0, 8'h00, 8'h00, 1, 0));
        add_request(CMD_PUT, 8'h00, 11'd0, 1'b1, mk_res(3, 0, 8'h00, 8'h00, 1, 0));
        add_request(CMD_READ, 8'h00, 11'd1, 1'b1, mk_res(3, 0, 8'hFF, RESET_ATTR, 0, 0));
        add_request(CMD_PUT, CHAR_BACKSPACE, 11'd0, 1'b0, '0);
        add_request(CMD_READ, 8'h00, 11'd2, 1'b0, '0);
        add_request(CMD_PUT, CHAR_NEWLINE, 11'd0, 1'b0, '0);
        add_request(CMD_PUT, 8'h7F, 11'd0, 1'b0, '0);
        add_attr(8'hFF);
        add_request(CMD_PUT, 8'h80, 11'd0, 1'b0, '0);
        add_request(CMD_READ, 8'h00, 11'd81, 1'b0, '0);
        add_attr(8'h00);
        add_request(CMD_PUT, CHAR_BACKSPACE, 11'd0, 1'b0, '0);
        add_request(CMD_READ, 8'h00, 11'd81, 1'b0, '0);
        add_request(CMD_CLEAR, 8'h55, 11'h2AA, 1'b1, mk_res(0, 0, 8'h00, 8'h00, 0, 1));
        add_request(CMD_READ, 8'h00, 11'd0, 1'b1, mk_res(0, 0, CHAR_BLANK, 8'h00, 0, 0));
        add_attr(RESET_ATTR);
        add_request(CMD_READ, 8'hAA, 11'd1023, 1'b0, '0);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (stim_table[i])
        begin
            if (stim_table[i].kind == ROW_ATTR)
                set_attribute(stim_table[i].attr);
            else
                send_req(stim_table[i].cmd, stim_table[i].ch, stim_table[i].idx,
                         stim_table[i].fixed, stim_table[i].want);
        end

        // Newline on the last row wipes the screen
        repeat (DEF_ROWS) send_req(CMD_PUT, CHAR_NEWLINE, 11'd0, 1'b0, '0);
        // Fill the last row so the final put wraps past it
        repeat (DEF_ROWS - 1) send_req(CMD_PUT, CHAR_NEWLINE, 11'd0, 1'b0, '0);
        repeat (DEF_COLUMNS)
            send_req(CMD_PUT, 8'($urandom_range(11, 255)), 11'($urandom_range(0, 2047)),
                     1'b0, '0);

        // Random phases, each under its own attribute
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: phase_attr = 8'h00;
                1: phase_attr = 8'hFF;
                4: phase_attr = RESET_ATTR;
                default: phase_attr = 8'($urandom_range(0, 255));
            endcase
            set_attribute(phase_attr);
            done = 0;
            no_gaps = 1'b1;
            while (done < PHASE_ITEMS)
            begin
                random_request(counted);
                if (counted)
                begin
                    done++;
                    if (done % 50 == 0)
                        no_gaps = ($urandom_range(0, 3) == 0);
                end
            end
        end

        // Drain and report
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (failures == 0)
            $display("text_console_writer regression: pass");
        else
            $display("text_console_writer regression: fail");
        $finish;
    end

endmodule

FILE: text_console_writer.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_queue.sv
hw/rtl/tcw_back.sv
hw/rtl/text_console_writer.sv
tb/tb_top.sv
